// ----- rtl/cbde_pkg.sv -----
// Package for the content identifier base32 digest extractor.
// Holds the sizing constants, state, configuration and result types and the symbol map.
// Depends on nothing; every other file in rtl imports it.
package cbde_pkg;

    localparam int ID_CHARS      = 59;
    localparam int CONTENT_BYTES = 36;
    localparam int DIGEST_BYTES  = 32;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODEC      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_TYPE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGEST_LEN = 3'd4;

    localparam logic [7:0] RST_PREFIX     = 8'd98;
    localparam logic [7:0] RST_VERSION    = 8'd1;
    localparam logic [7:0] RST_CODEC      = 8'd85;
    localparam logic [7:0] RST_HASH_TYPE  = 8'd18;
    localparam logic [7:0] RST_DIGEST_LEN = 8'd32;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_TWO   = 8'h32;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;
    localparam logic [4:0] DIGIT_BASE = 5'd26;

    localparam logic [6:0] CHAR_COUNT_MAX = 7'd127;
    localparam logic [5:0] BYTE_COUNT_MAX = 6'd63;

    typedef struct packed {
        logic [7:0] prefix_char;
        logic [7:0] expected_version;
        logic [7:0] expected_codec;
        logic [7:0] expected_hash_type;
        logic [7:0] expected_digest_len;
    } cbde_cfg_t;

    typedef struct packed {
        logic [6:0]  char_count;
        logic [11:0] bit_buffer;
        logic [3:0]  bit_count;
        logic [5:0]  byte_count;
        logic        pad_seen;
        logic        failed;
    } cbde_state_t;

    typedef struct packed {
        logic       present;
        logic       byte_valid;
        logic [7:0] digest_byte;
        logic [4:0] digest_index;
        logic       done_res;
        logic       cid_ok;
    } cbde_result_t;

    // Bit 5 set marks a character that is not a base32 symbol.
    function automatic logic [5:0] symbol_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= CHAR_UP_A && c <= CHAR_UP_Z)
            begin
                d = c - CHAR_UP_A;
                symbol_value = {1'b0, d[4:0]};
            end
            else if (c >= CHAR_LO_A && c <= CHAR_LO_Z)
            begin
                d = c - CHAR_LO_A;
                symbol_value = {1'b0, d[4:0]};
            end
            else if (c >= CHAR_TWO && c <= CHAR_SEVEN)
            begin
                d = c - CHAR_TWO;
                symbol_value = {1'b0, d[4:0] + DIGIT_BASE};
            end
            else
            begin
                symbol_value = 6'b100000;
            end
        end
    endfunction

endpackage

// ----- rtl/cbde_cfg.sv -----
// Configuration register file of the digest extractor.
// Holds the prefix character and the four expected header bytes; uses cbde_pkg.
module cbde_cfg
    import cbde_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output cbde_cfg_t            cfg
);

    cbde_cfg_t cfg_reg;
    cbde_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PREFIX:     cfg_next.prefix_char         = cfg_data;
                CFG_VERSION:    cfg_next.expected_version    = cfg_data;
                CFG_CODEC:      cfg_next.expected_codec      = cfg_data;
                CFG_HASH_TYPE:  cfg_next.expected_hash_type  = cfg_data;
                CFG_DIGEST_LEN: cfg_next.expected_digest_len = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prefix_char         <= RST_PREFIX;
            cfg_reg.expected_version    <= RST_VERSION;
            cfg_reg.expected_codec      <= RST_CODEC;
            cfg_reg.expected_hash_type  <= RST_HASH_TYPE;
            cfg_reg.expected_digest_len <= RST_DIGEST_LEN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/cbde_step.sv -----
// Decode step of the digest extractor: one character against the running state.
// Gives the next state and the result item; uses cbde_pkg.
module cbde_step
    import cbde_pkg::*;
(
    input  cbde_cfg_t    cfg,
    input  cbde_state_t  state,
    input  logic [7:0]   char_code,
    input  logic         last_char,
    output cbde_state_t  state_next,
    output cbde_result_t result
);

    localparam logic [6:0] CONTENT_LIMIT = 7'(CONTENT_BYTES);
    localparam logic [6:0] DIGEST_LIMIT  = 7'(DIGEST_BYTES);
    localparam logic [6:0] ID_LIMIT      = 7'(ID_CHARS);

    logic        first;
    logic [5:0]  sym;
    logic [11:0] shifted;
    logic [3:0]  bits_added;
    logic [3:0]  bits_left;
    logic [11:0] byte_wide;
    logic [7:0]  dbyte;
    logic [5:0]  n;
    logic [6:0]  dig_pos;
    logic        emit;
    cbde_state_t ns;

    always_comb
    begin
        ns = state;
        emit = 1'b0;
        dbyte = 8'd0;
        first = (state.char_count == 7'd0);
        sym = symbol_value(char_code);
        shifted = {state.bit_buffer[6:0], sym[4:0]};
        bits_added = state.bit_count + 4'd5;
        bits_left = bits_added - 4'd8;
        byte_wide = shifted >> bits_left;
        n = state.byte_count;
        dig_pos = {1'b0, n} - 7'd4;

        if (state.char_count != CHAR_COUNT_MAX)
        begin
            ns.char_count = state.char_count + 7'd1;
        end

        if (first)
        begin
            if (char_code != cfg.prefix_char)
            begin
                ns.failed = 1'b1;
            end
        end
        else if (!state.pad_seen && !state.failed)
        begin
            if (char_code == CHAR_PAD)
            begin
                ns.pad_seen = 1'b1;
            end
            else if (sym[5])
            begin
                ns.failed = 1'b1;
            end
            else if (bits_added < 4'd8)
            begin
                ns.bit_buffer = shifted;
                ns.bit_count = bits_added;
            end
            else
            begin
                ns.bit_count = bits_left;
                ns.bit_buffer = shifted & ((12'd1 << bits_left) - 12'd1);
                if ({1'b0, n} >= CONTENT_LIMIT)
                begin
                    ns.failed = 1'b1;
                end
                else
                begin
                    if (n != BYTE_COUNT_MAX)
                    begin
                        ns.byte_count = n + 6'd1;
                    end
                    case (n)
                        6'd0:
                        begin
                            if (byte_wide[7:0] != cfg.expected_version) ns.failed = 1'b1;
                        end
                        6'd1:
                        begin
                            if (byte_wide[7:0] != cfg.expected_codec) ns.failed = 1'b1;
                        end
                        6'd2:
                        begin
                            if (byte_wide[7:0] != cfg.expected_hash_type) ns.failed = 1'b1;
                        end
                        6'd3:
                        begin
                            if (byte_wide[7:0] != cfg.expected_digest_len) ns.failed = 1'b1;
                        end
                        default:
                        begin
                            if (dig_pos < DIGEST_LIMIT)
                            begin
                                emit = 1'b1;
                                dbyte = byte_wide[7:0];
                            end
                        end
                    endcase
                end
            end
        end

        result.present = emit || last_char;
        result.byte_valid = emit;
        result.digest_byte = dbyte;
        result.digest_index = emit ? dig_pos[4:0] : 5'd0;
        result.done_res = last_char;
        result.cid_ok = last_char && !ns.failed && (ns.char_count == ID_LIMIT)
                        && ({1'b0, ns.byte_count} == CONTENT_LIMIT);

        state_next = ns;
        if (last_char)
        begin
            state_next = '0;
        end
    end

endmodule

// ----- rtl/cid_base32_digest_extractor_top.sv -----
// Path: an accepted item is held in the input register, passes the decode step and, if it
// gives a result item, is registered in the result register, which drives the outputs.
// Throughput: one character item per cycle while results are taken, set by the single decode
// step between the input and result registers; a stalled result holds the input register.
// Reset clears the decode state and the valid flags of both pipeline registers and loads
// the default configuration: prefix 'b', version 1, codec 85, hash type 18, digest length 32.
module cid_base32_digest_extractor_top
    import cbde_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [7:0]           char_code,
    input  logic                 last_char,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic                 byte_valid,
    output logic [7:0]           digest_byte,
    output logic [4:0]           digest_index,
    output logic                 done_res,
    output logic                 cid_ok,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    cbde_cfg_t    cfg;
    cbde_state_t  state_reg;
    cbde_state_t  state_next;
    cbde_result_t step_res;
    cbde_result_t res_reg;

    logic       in_vld_reg;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       out_vld_reg;
    logic       out_free;
    logic       advance;
    logic       take;

    cbde_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cbde_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .char_code  (char_reg),
        .last_char  (last_reg),
        .state_next (state_next),
        .result     (step_res)
    );

    assign out_free = !out_vld_reg || !result_stall;
    assign advance = in_vld_reg && out_free;
    assign item_stall = in_vld_reg && !out_free;
    assign take = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg <= '0;
        end
        else
        begin
            if (take)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end
            if (out_free)
            begin
                out_vld_reg <= advance && step_res.present;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            char_reg <= char_code;
            last_reg <= last_char;
        end
        if (advance && step_res.present)
        begin
            res_reg <= step_res;
        end
    end

    assign result_valid = out_vld_reg;
    assign byte_valid = res_reg.byte_valid;
    assign digest_byte = res_reg.digest_byte;
    assign digest_index = res_reg.digest_index;
    assign done_res = res_reg.done_res;
    assign cid_ok = res_reg.cid_ok;

endmodule
